// ----- hdl/nei_pkg.sv -----
// Shared types, constants and helpers for the navmesh edge interest point block.
// No dependencies; imported by nei_math and the top level.
package nei_pkg;

  localparam int NEI_MAX_VERTS = 16;
  localparam int RESULT_LIMIT  = 32;
  localparam int CNT_W         = 6;
  localparam int DIV_W         = 48;

  localparam logic [15:0] NUDGE_CENTER = 16'd6554;
  localparam logic [15:0] NUDGE_ALONG  = 16'd32768;

  localparam logic [2:0] REG_ORIGIN_X    = 3'd0;
  localparam logic [2:0] REG_ORIGIN_Y    = 3'd1;
  localparam logic [2:0] REG_ORIGIN_UP   = 3'd2;
  localparam logic [2:0] REG_CELL_SIZE   = 3'd3;
  localparam logic [2:0] REG_CELL_HEIGHT = 3'd4;

  typedef enum logic [0:0] {
    MOP_DIV  = 1'b0,
    MOP_SQRT = 1'b1
  } mop_t;

  typedef struct packed {
    logic start;
    mop_t op;
  } math_req_t;

  function automatic logic signed [31:0] sat32(input logic signed [37:0] v);
    if (v > 38'sd2147483647) return 32'sh7fffffff;
    if (v < -38'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

endpackage

// ----- hdl/navmesh_edge_interest_points_core.sv -----
// Top level of the navmesh edge interest point block: APB register file,
// vertex memory, edge walk sequencer and output register. Depends on nei_pkg, nei_math.
//
// Usage: send one polygon vertex per item on the vertex channel (vertex_valid /
// vertex_stall); mark the final vertex with last_vertex. Each vertex is scaled
// to Q16.16 world space and written to the vertex memory in S_VTX; the block
// then takes the next item. On the last vertex the block computes the centre
// (three divides) and walks the edges one at a time. Scaling a vector uses the
// shared divide/square-root unit, and a long edge needs up to three scalings;
// vertex_stall stays high during the walk.
// Interest points leave on the point channel (point_valid / point_stall);
// last_point marks the final point of a polygon. One point is held back so the
// last one can be marked; a stalled receiver freezes the walk when both the
// output register and the held point are full. Reset clears the registers to
// their defaults, the vertex count and the running sums; the vertex memory is
// not cleared, only entries of the current polygon are read.
module navmesh_edge_interest_points_core import nei_pkg::*; #(
  parameter int MAX_VERTS = NEI_MAX_VERTS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               vertex_valid,
  output logic               vertex_stall,
  input  logic [15:0]        grid_x,
  input  logic [15:0]        grid_height,
  input  logic [15:0]        grid_depth,
  input  logic               open_edge,
  input  logic               last_vertex,
  output logic               point_valid,
  input  logic               point_stall,
  output logic signed [31:0] world_x,
  output logic signed [31:0] world_y,
  output logic signed [31:0] world_z,
  output logic               last_point
);

  localparam int AW    = $clog2(MAX_VERTS);
  localparam int CW    = $clog2(MAX_VERTS + 1);
  localparam int SUM_W = 32 + $clog2(MAX_VERTS);
  localparam int DVD_W = SUM_W + 1;
  localparam int ENT_W = 97;
  localparam logic [CW-1:0] N_MAX = CW'(MAX_VERTS);

  typedef enum logic [21:0] {
    S_IDLE    = 22'd1 << 0,
    S_VTX     = 22'd1 << 1,
    S_CEN     = 22'd1 << 2,
    S_CENW    = 22'd1 << 3,
    S_LD0     = 22'd1 << 4,
    S_LD1     = 22'd1 << 5,
    S_LD2     = 22'd1 << 6,
    S_CAP     = 22'd1 << 7,
    S_EDGE    = 22'd1 << 8,
    S_PA      = 22'd1 << 9,
    S_PB      = 22'd1 << 10,
    S_NUDGE   = 22'd1 << 11,
    S_SC_SQ   = 22'd1 << 12,
    S_SC_RT   = 22'd1 << 13,
    S_SC_RTW  = 22'd1 << 14,
    S_SC_MUL  = 22'd1 << 15,
    S_SC_DIVW = 22'd1 << 16,
    S_SC_END  = 22'd1 << 17,
    S_EM_ADD  = 22'd1 << 18,
    S_EM_OUT  = 22'd1 << 19,
    S_NEXT    = 22'd1 << 20,
    S_FLUSH   = 22'd1 << 21
  } state_t;

  typedef enum logic [1:0] {
    PH_MID = 2'd0,
    PH_A   = 2'd1,
    PH_B   = 2'd2
  } phase_t;

  // configuration
  logic signed [31:0] origin_x, origin_y, origin_up;
  logic [19:0]        cell_size, cell_height;
  logic [2:0]         reg_idx;
  logic               reg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign reg_wr  = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x    <= '0;
      origin_y    <= '0;
      origin_up   <= '0;
      cell_size   <= 20'd65536;
      cell_height <= 20'd65536;
    end else if (reg_wr) begin
      unique case (reg_idx)
        REG_ORIGIN_X:    origin_x    <= pwdata;
        REG_ORIGIN_Y:    origin_y    <= pwdata;
        REG_ORIGIN_UP:   origin_up   <= pwdata;
        REG_CELL_SIZE:   cell_size   <= pwdata[19:0];
        REG_CELL_HEIGHT: cell_height <= pwdata[19:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_ORIGIN_X:    prdata = origin_x;
      REG_ORIGIN_Y:    prdata = origin_y;
      REG_ORIGIN_UP:   prdata = origin_up;
      REG_CELL_SIZE:   prdata = {12'd0, cell_size};
      REG_CELL_HEIGHT: prdata = {12'd0, cell_height};
      default:         prdata = '0;
    endcase
  end

  // control and datapath registers
  state_t             state;
  state_t             sc_ret;
  phase_t             ph;
  logic [CW-1:0]      count;
  logic [AW-1:0]      nx;
  logic [1:0]         ck;
  logic [1:0]         sj;
  logic [CNT_W-1:0]   cnt;
  logic               pend_v;
  logic               a_ok;
  logic               sc_along;
  logic [15:0]        sc_k;
  logic [15:0]        gx, gh, gd;
  logic               g_open, g_last;
  logic signed [SUM_W-1:0] sum [3];
  logic signed [31:0] cen [3];
  logic signed [31:0] s_pos [3];
  logic signed [31:0] e_pos [3];
  logic signed [31:0] em_pos [3];
  logic signed [31:0] pt [3];
  logic signed [31:0] pend [3];
  logic signed [16:0] em_along [3];
  logic signed [16:0] a_fwd [3];
  logic signed [16:0] so [3];
  logic [31:0]        sm [3];
  logic [2:0]         sneg;
  logic [63:0]        acc;
  logic [31:0]        len;
  logic               f_prev, f_cur, f_nx, f_last;

  // vertex memory
  logic [ENT_W-1:0]   mem [MAX_VERTS];
  logic [ENT_W-1:0]   rd_q;
  logic [AW-1:0]      raddr;
  logic               mem_wr;
  logic [ENT_W-1:0]   mem_wdata;

  // vertex scaling
  logic [35:0]        px, py, pz;
  logic signed [31:0] vx, vy, vz;

  assign px = gx * cell_size;
  assign py = gd * cell_size;
  assign pz = gh * cell_height;
  assign vx = sat32(38'(origin_x) + $signed({2'b00, px}));
  assign vy = sat32(38'(origin_y) + $signed({2'b00, py}));
  assign vz = sat32(38'(origin_up) + $signed({2'b00, pz}));

  assign mem_wr    = (state == S_VTX) && (count < N_MAX);
  assign mem_wdata = {g_open, vz, vy, vx};

  always_ff @(posedge clk) begin
    if (mem_wr) mem[count[AW-1:0]] <= mem_wdata;
  end

  always_ff @(posedge clk) begin
    rd_q <= mem[raddr];
  end

  always_comb begin
    unique case (state)
      S_LD0:   raddr = AW'(count - CW'(2));
      S_LD1:   raddr = AW'(count - CW'(1));
      S_LD2:   raddr = '0;
      S_NEXT:  raddr = nx + AW'(1);
      default: raddr = nx;
    endcase
  end

  // edge classification
  logic signed [32:0] d [3];
  logic [32:0]        dm [3];
  logic [33:0]        dsq [3];
  logic [35:0]        qsum;
  logic               big, q_small, q_mid;
  logic signed [31:0] mid [3];
  logic signed [32:0] msum [3];
  logic signed [32:0] tc [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      d[k]    = 33'(e_pos[k]) - 33'(s_pos[k]);
      dm[k]   = d[k][32] ? 33'(-d[k]) : 33'(d[k]);
      dsq[k]  = dm[k][16:0] * dm[k][16:0];
      msum[k] = 33'(s_pos[k]) + 33'(e_pos[k]);
      mid[k]  = msum[k][32:1];
      tc[k]   = 33'(cen[k]) - 33'(em_pos[k]);
    end
    big     = (|dm[0][32:17]) | (|dm[1][32:17]) | (|dm[2][32:17]);
    qsum    = 36'(dsq[0]) + 36'(dsq[1]) + 36'(dsq[2]);
    q_small = qsum < 36'h0_4000_0000;
    q_mid   = qsum < 36'h4_0000_0000;
  end

  // scale launch: magnitudes of the vector to scale
  logic signed [32:0] sc_vec [3];
  logic [32:0]        sc_mag [3];
  logic [31:0]        sc_m [3];
  logic               sc_shift;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sc_vec[k] = (state == S_NUDGE) ? tc[k] : d[k];
      sc_mag[k] = sc_vec[k][32] ? 33'(-sc_vec[k]) : 33'(sc_vec[k]);
    end
    sc_shift = (|sc_mag[0][32:31]) | (|sc_mag[1][32:31]) | (|sc_mag[2][32:31]);
    for (int k = 0; k < 3; k++) begin
      sc_m[k] = sc_shift ? sc_mag[k][32:1] : sc_mag[k][31:0];
    end
  end

  // centre divide operands
  logic signed [SUM_W-1:0] sum_sel;
  logic                    cen_neg;
  logic [SUM_W-1:0]        cen_mag;
  logic [DVD_W-1:0]        cen_dvd;

  assign sum_sel = sum[ck];
  assign cen_neg = sum_sel[SUM_W-1];
  assign cen_mag = cen_neg ? SUM_W'(-sum_sel) : SUM_W'(sum_sel);
  assign cen_dvd = {1'b0, cen_mag} + (cen_neg ? DVD_W'(count - CW'(1)) : '0);

  // shared arithmetic unit
  math_req_t   mreq;
  logic [63:0] mopa;
  logic [31:0] mopb;
  logic        mdone;
  logic [63:0] mres;
  logic [63:0] sq_p;
  logic [47:0] mk;

  assign sq_p = sm[sj] * sm[sj];
  assign mk   = sm[sj] * sc_k;

  always_comb begin
    mreq.start = 1'b0;
    mreq.op    = MOP_DIV;
    mopa       = '0;
    mopb       = '0;
    unique case (state)
      S_CEN: begin
        mreq.start = count >= CW'(3);
        mopa       = 64'(cen_dvd);
        mopb       = 32'(count);
      end
      S_SC_RT: begin
        mreq.start = 1'b1;
        mreq.op    = MOP_SQRT;
        mopa       = acc;
      end
      S_SC_MUL: begin
        mreq.start = 1'b1;
        mopa       = 64'(mk);
        mopb       = len;
      end
      default: ;
    endcase
  end

  nei_math u_math (
    .clk  (clk),
    .rst  (rst),
    .req  (mreq),
    .opa  (mopa),
    .opb  (mopb),
    .done (mdone),
    .res  (mres)
  );

  // output slot and return target of an emit
  logic   slot_free;
  logic   out_load;
  state_t em_ret;
  logic   at_end;

  assign slot_free    = !point_valid || !point_stall;
  assign out_load     = slot_free && pend_v && ((state == S_EM_OUT) || (state == S_FLUSH));
  assign em_ret       = (ph == PH_A) ? S_PB : S_NEXT;
  assign at_end       = (CW'(nx) + CW'(1)) == count;
  assign vertex_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      sc_ret      <= S_IDLE;
      ph          <= PH_MID;
      count       <= '0;
      nx          <= '0;
      ck          <= '0;
      sj          <= '0;
      cnt         <= '0;
      pend_v      <= 1'b0;
      a_ok        <= 1'b0;
      sc_along    <= 1'b0;
      point_valid <= 1'b0;
      for (int k = 0; k < 3; k++) sum[k] <= '0;
    end else begin
      if (out_load) begin
        point_valid <= 1'b1;
      end else if (!point_stall) begin
        point_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (vertex_valid) begin
            gx     <= grid_x;
            gh     <= grid_height;
            gd     <= grid_depth;
            g_open <= open_edge;
            g_last <= last_vertex;
            state  <= S_VTX;
          end
        end
        S_VTX: begin
          if (count < N_MAX) begin
            sum[0] <= sum[0] + SUM_W'(vx);
            sum[1] <= sum[1] + SUM_W'(vy);
            sum[2] <= sum[2] + SUM_W'(vz);
            count  <= count + CW'(1);
          end
          ck     <= '0;
          cnt    <= '0;
          pend_v <= 1'b0;
          state  <= g_last ? S_CEN : S_IDLE;
        end
        S_CEN: begin
          if (count < CW'(3)) begin
            count <= '0;
            for (int k = 0; k < 3; k++) sum[k] <= '0;
            state <= S_IDLE;
          end else begin
            state <= S_CENW;
          end
        end
        S_CENW: begin
          if (mdone) begin
            cen[ck] <= cen_neg ? -mres[31:0] : mres[31:0];
            if (ck == 2'd2) begin
              state <= S_LD0;
            end else begin
              ck    <= ck + 2'd1;
              state <= S_CEN;
            end
          end
        end
        S_LD0: state <= S_LD1;
        S_LD1: begin
          f_prev <= rd_q[96];
          state  <= S_LD2;
        end
        S_LD2: begin
          s_pos[0] <= rd_q[31:0];
          s_pos[1] <= rd_q[63:32];
          s_pos[2] <= rd_q[95:64];
          f_cur    <= rd_q[96];
          nx       <= '0;
          state    <= S_CAP;
        end
        S_CAP: begin
          e_pos[0] <= rd_q[31:0];
          e_pos[1] <= rd_q[63:32];
          e_pos[2] <= rd_q[95:64];
          f_nx     <= at_end ? f_last : rd_q[96];
          a_ok     <= 1'b0;
          state    <= S_EDGE;
        end
        S_EDGE: begin
          if (!f_cur) begin
            state <= S_NEXT;
          end else if (!big && q_small) begin
            f_cur <= 1'b0;
            state <= S_NEXT;
          end else if (!big && q_mid) begin
            if (f_prev || f_nx) begin
              f_cur <= 1'b0;
              state <= S_NEXT;
            end else begin
              for (int k = 0; k < 3; k++) begin
                em_pos[k]   <= mid[k];
                em_along[k] <= '0;
              end
              ph    <= PH_MID;
              state <= S_NUDGE;
            end
          end else begin
            state <= S_PA;
          end
        end
        S_PA: begin
          if (f_prev) begin
            if (nx == AW'(1)) begin
              state <= S_PB;
            end else begin
              for (int k = 0; k < 3; k++) begin
                em_pos[k]   <= s_pos[k];
                em_along[k] <= '0;
              end
              ph    <= PH_A;
              state <= S_NUDGE;
            end
          end else if (!a_ok) begin
            for (int k = 0; k < 3; k++) begin
              sm[k]   <= sc_m[k];
              sneg[k] <= sc_vec[k][32];
            end
            acc      <= '0;
            sj       <= '0;
            sc_k     <= NUDGE_ALONG;
            sc_along <= 1'b1;
            sc_ret   <= S_PA;
            state    <= S_SC_SQ;
          end else begin
            for (int k = 0; k < 3; k++) begin
              em_pos[k]   <= s_pos[k];
              em_along[k] <= a_fwd[k];
            end
            ph    <= PH_A;
            state <= S_NUDGE;
          end
        end
        S_PB: begin
          if (f_nx) begin
            if (nx == '0) begin
              for (int k = 0; k < 3; k++) begin
                em_pos[k]   <= e_pos[k];
                em_along[k] <= '0;
              end
              ph    <= PH_B;
              state <= S_NUDGE;
            end else begin
              state <= S_NEXT;
            end
          end else if (!a_ok) begin
            for (int k = 0; k < 3; k++) begin
              sm[k]   <= sc_m[k];
              sneg[k] <= sc_vec[k][32];
            end
            acc      <= '0;
            sj       <= '0;
            sc_k     <= NUDGE_ALONG;
            sc_along <= 1'b1;
            sc_ret   <= S_PB;
            state    <= S_SC_SQ;
          end else begin
            for (int k = 0; k < 3; k++) begin
              em_pos[k]   <= e_pos[k];
              em_along[k] <= -a_fwd[k];
            end
            ph    <= PH_B;
            state <= S_NUDGE;
          end
        end
        S_NUDGE: begin
          if (cnt >= CNT_W'(RESULT_LIMIT)) begin
            state <= em_ret;
          end else begin
            for (int k = 0; k < 3; k++) begin
              sm[k]   <= sc_m[k];
              sneg[k] <= sc_vec[k][32];
            end
            acc      <= '0;
            sj       <= '0;
            sc_k     <= NUDGE_CENTER;
            sc_along <= 1'b0;
            sc_ret   <= S_EM_ADD;
            state    <= S_SC_SQ;
          end
        end
        S_SC_SQ: begin
          acc <= acc + sq_p;
          if (sj == 2'd2) begin
            sj    <= '0;
            state <= S_SC_RT;
          end else begin
            sj <= sj + 2'd1;
          end
        end
        S_SC_RT: state <= S_SC_RTW;
        S_SC_RTW: begin
          if (mdone) begin
            len <= mres[31:0];
            sj  <= '0;
            if (mres[31:0] == '0) begin
              for (int k = 0; k < 3; k++) so[k] <= '0;
              state <= S_SC_END;
            end else begin
              state <= S_SC_MUL;
            end
          end
        end
        S_SC_MUL: state <= S_SC_DIVW;
        S_SC_DIVW: begin
          if (mdone) begin
            so[sj] <= sneg[sj] ? -$signed({1'b0, mres[15:0]}) : $signed({1'b0, mres[15:0]});
            if (sj == 2'd2) begin
              state <= S_SC_END;
            end else begin
              sj    <= sj + 2'd1;
              state <= S_SC_MUL;
            end
          end
        end
        S_SC_END: begin
          if (sc_along) begin
            for (int k = 0; k < 3; k++) a_fwd[k] <= so[k];
            a_ok <= 1'b1;
          end
          state <= sc_ret;
        end
        S_EM_ADD: begin
          for (int k = 0; k < 3; k++) begin
            pt[k] <= sat32(38'(em_pos[k]) + 38'(so[k]) + 38'(em_along[k]));
          end
          state <= S_EM_OUT;
        end
        S_EM_OUT: begin
          if (!pend_v) begin
            for (int k = 0; k < 3; k++) pend[k] <= pt[k];
            pend_v <= 1'b1;
            cnt    <= cnt + CNT_W'(1);
            state  <= em_ret;
          end else if (slot_free) begin
            world_x     <= pend[0];
            world_y     <= pend[1];
            world_z     <= pend[2];
            last_point  <= 1'b0;
            for (int k = 0; k < 3; k++) pend[k] <= pt[k];
            cnt   <= cnt + CNT_W'(1);
            state <= em_ret;
          end
        end
        S_NEXT: begin
          if (nx == '0) f_last <= f_cur;
          f_prev <= f_cur;
          f_cur  <= f_nx;
          for (int k = 0; k < 3; k++) s_pos[k] <= e_pos[k];
          if (at_end) begin
            state <= S_FLUSH;
          end else begin
            nx    <= nx + AW'(1);
            state <= S_CAP;
          end
        end
        S_FLUSH: begin
          if (!pend_v || slot_free) begin
            if (pend_v) begin
              world_x     <= pend[0];
              world_y     <= pend[1];
              world_z     <= pend[2];
              last_point  <= 1'b1;
            end
            pend_v <= 1'b0;
            count  <= '0;
            for (int k = 0; k < 3; k++) sum[k] <= '0;
            state  <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_cnt_limit: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(RESULT_LIMIT))
    else $error("emitted point count beyond limit");

  a_pend_cnt: assert property (@(posedge clk) disable iff (rst)
    pend_v |-> (cnt != '0))
    else $error("held point without count");

  a_math_done: assert property (@(posedge clk) disable iff (rst)
    mdone |-> (state == S_CENW || state == S_SC_RTW || state == S_SC_DIVW))
    else $error("arithmetic result arrived outside a wait state");

  a_walk_size: assert property (@(posedge clk) disable iff (rst)
    (state == S_EDGE) |-> (count >= CW'(3)))
    else $error("edge walk on a polygon below three vertices");

endmodule

// ----- hdl/nei_math.sv -----
// Iterative arithmetic unit: restoring divide (one quotient bit per cycle)
// and integer square root (one result bit per cycle). Depends on nei_pkg.
module nei_math import nei_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  math_req_t   req,
  input  logic [63:0] opa,
  input  logic [31:0] opb,
  output logic        done,
  output logic [63:0] res
);

  logic             busy;
  mop_t             op;
  logic [5:0]       steps;
  logic [31:0]      dsr;
  logic [31:0]      rem;
  logic [DIV_W-1:0] quo;
  logic [63:0]      x;
  logic [63:0]      r;
  logic [63:0]      bit_w;
  logic [32:0]      trial;
  logic             ge;
  logic [63:0]      rb;

  assign trial = {rem, quo[DIV_W-1]};
  assign ge    = trial >= {1'b0, dsr};
  assign rb    = r + bit_w;
  assign res   = (op == MOP_SQRT) ? r : 64'(quo);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
      op    <= MOP_DIV;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        op    <= req.op;
        steps <= (req.op == MOP_SQRT) ? 6'd32 : 6'(DIV_W);
      end else if (busy) begin
        steps <= steps - 6'd1;
        if (steps == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dsr   <= opb;
      rem   <= '0;
      quo   <= opa[DIV_W-1:0];
      x     <= opa;
      r     <= '0;
      bit_w <= 64'h4000_0000_0000_0000;
    end else if (busy) begin
      if (op == MOP_DIV) begin
        rem <= ge ? 32'(trial - {1'b0, dsr}) : trial[31:0];
        quo <= {quo[DIV_W-2:0], ge};
      end else begin
        if (x >= rb) begin
          x <= x - rb;
          r <= (r >> 1) + bit_w;
        end else begin
          r <= r >> 1;
        end
        bit_w <= bit_w >> 2;
      end
    end
  end

endmodule
